[rtl/slmb_pkg.sv]
// Package for the status LED mode blinker.
// Holds item, result and configuration types, mode and kind codes and the palette.
// Used by every other file of the block but slmb_if; depends on nothing.
package slmb_pkg;

  typedef logic [23:0] rgb_t;

  localparam logic [2:0] KIND_TICK         = 3'd0;
  localparam logic [2:0] KIND_SET_MODE     = 3'd1;
  localparam logic [2:0] KIND_ENTER_CONFIG = 3'd2;
  localparam logic [2:0] KIND_SET_COLOR    = 3'd3;
  localparam logic [2:0] KIND_CLEAR_COLOR  = 3'd4;

  localparam logic [1:0] MODE_IDLE     = 2'd0;
  localparam logic [1:0] MODE_HUB_WAIT = 2'd1;
  localparam logic [1:0] MODE_LINKED   = 2'd2;
  localparam logic [1:0] MODE_CONFIG   = 2'd3;

  localparam logic [1:0] REG_NODE_ID          = 2'd0;
  localparam logic [1:0] REG_BLINK_TICKS      = 2'd1;
  localparam logic [1:0] REG_FAST_BLINK_TICKS = 2'd2;

  localparam rgb_t RGB_WHITE = 24'hFFFFFF;
  localparam rgb_t RGB_BLACK = 24'h000000;

  localparam logic [7:0] NODE_ID_RESET          = 8'd0;
  localparam logic [7:0] BLINK_TICKS_RESET      = 8'd40;
  localparam logic [7:0] FAST_BLINK_TICKS_RESET = 8'd10;

  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] mode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] led_red;
    logic [7:0] led_green;
    logic [7:0] led_blue;
    logic [1:0] active_mode;
    logic       in_config;
  } result_t;

  typedef struct packed {
    logic [7:0] node_id;
    logic [7:0] blink_ticks;
    logic [7:0] fast_blink_ticks;
  } cfg_t;

  // Colour belonging to a node number; numbers of ten and above show white.
  function automatic rgb_t palette_color(input logic [7:0] node_id);
    rgb_t c;
    case (node_id)
      8'd0:    c = 24'hFFFFFF;
      8'd1:    c = 24'hFF0000;
      8'd2:    c = 24'h00FF00;
      8'd3:    c = 24'h0000FF;
      8'd4:    c = 24'h00FFFF;
      8'd5:    c = 24'hFF00FF;
      8'd6:    c = 24'hFFFF00;
      8'd7:    c = 24'h9400D3;
      8'd8:    c = 24'hFF5A00;
      8'd9:    c = 24'h800000;
      default: c = RGB_WHITE;
    endcase
    return c;
  endfunction

endpackage

[rtl/slmb_if.sv]
// Valid/ready channel interface for the status LED mode blinker.
// The payload type is given at instantiation; depends on nothing else.
interface slmb_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[rtl/slmb_cfg.sv]
// Configuration registers of the status LED mode blinker.
// Depends on slmb_pkg for the register indexes and the cfg_t type.
module slmb_cfg (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [7:0]       cfg_data,
  output slmb_pkg::cfg_t   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_id          <= slmb_pkg::NODE_ID_RESET;
      cfg.blink_ticks      <= slmb_pkg::BLINK_TICKS_RESET;
      cfg.fast_blink_ticks <= slmb_pkg::FAST_BLINK_TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        slmb_pkg::REG_NODE_ID:          cfg.node_id          <= cfg_data;
        slmb_pkg::REG_BLINK_TICKS:      cfg.blink_ticks      <= cfg_data;
        slmb_pkg::REG_FAST_BLINK_TICKS: cfg.fast_blink_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[rtl/slmb_in_reg.sv]
// Input register of the status LED mode blinker.
// Captures one item and offers it to the control stage; depends on slmb_pkg.
module slmb_in_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  slmb_pkg::in_item_t  in_data,
  output logic                stage_valid,
  input  logic                stage_ready,
  output slmb_pkg::in_item_t  stage_data
);

  logic held;

  // The register refills in the same cycle that its item moves on.
  assign in_ready    = !held || stage_ready;
  assign stage_valid = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_data <= in_data;
    end
  end

endmodule

[rtl/slmb_ctrl.sv]
// Mode, override and blink cycle state of the status LED mode blinker,
// with the result register. Depends on slmb_pkg.
module slmb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  slmb_pkg::cfg_t      cfg,
  input  logic                item_valid,
  output logic                item_ready,
  input  slmb_pkg::in_item_t  item,
  output logic                res_valid,
  input  logic                res_ready,
  output slmb_pkg::result_t   res
);

  logic [1:0]     cur_mode, cur_mode_next;
  logic           ovr_valid, ovr_valid_next;
  slmb_pkg::rgb_t ovr_color, ovr_color_next;
  logic [1:0]     cycle_mode, cycle_mode_next;
  slmb_pkg::rgb_t cycle_base, cycle_base_next;
  logic           cycle_phase, cycle_phase_next;
  logic [7:0]     phase_ticks, phase_ticks_next;
  slmb_pkg::rgb_t shown, shown_next;

  slmb_pkg::rgb_t base_now;
  slmb_pkg::rgb_t start_shown;
  logic [7:0]     len_raw;
  logic [7:0]     len;
  logic [7:0]     ticks_inc;
  logic           phase_done;
  logic           take;

  assign item_ready = !res_valid || res_ready;
  assign take       = item_valid && item_ready;

  assign base_now    = ovr_valid ? ovr_color : slmb_pkg::palette_color(cfg.node_id);
  assign start_shown = (cur_mode == slmb_pkg::MODE_CONFIG) ? slmb_pkg::RGB_WHITE : base_now;
  assign len_raw     = (cycle_mode == slmb_pkg::MODE_CONFIG) ? cfg.fast_blink_ticks
                                                             : cfg.blink_ticks;
  assign len         = (len_raw == 8'd0) ? 8'd1 : len_raw;
  assign ticks_inc   = phase_ticks + 8'd1;
  assign phase_done  = ticks_inc >= len;

  always_comb begin
    cur_mode_next    = cur_mode;
    ovr_valid_next   = ovr_valid;
    ovr_color_next   = ovr_color;
    cycle_mode_next  = cycle_mode;
    cycle_base_next  = cycle_base;
    cycle_phase_next = cycle_phase;
    phase_ticks_next = phase_ticks;
    shown_next       = shown;
    case (item.kind)
      slmb_pkg::KIND_TICK: begin
        phase_ticks_next = ticks_inc;
        if (phase_done) begin
          if (cycle_mode == slmb_pkg::MODE_LINKED || cycle_phase) begin
            cycle_mode_next  = cur_mode;
            cycle_base_next  = base_now;
            cycle_phase_next = 1'b0;
            phase_ticks_next = 8'd0;
            shown_next       = start_shown;
          end else begin
            cycle_phase_next = 1'b1;
            phase_ticks_next = 8'd0;
            shown_next       = slmb_pkg::RGB_BLACK;
          end
        end
        // A restart with unchanged mode and colour gives the same state again,
        // so the abort check may simply restart from the current state.
        if (cur_mode != cycle_mode_next ||
            (cycle_mode_next != slmb_pkg::MODE_CONFIG && base_now != cycle_base_next)) begin
          cycle_mode_next  = cur_mode;
          cycle_base_next  = base_now;
          cycle_phase_next = 1'b0;
          phase_ticks_next = 8'd0;
          shown_next       = start_shown;
        end
      end
      slmb_pkg::KIND_SET_MODE: begin
        if (!(cur_mode == slmb_pkg::MODE_CONFIG && item.mode == slmb_pkg::MODE_IDLE)) begin
          cur_mode_next = item.mode;
        end
      end
      slmb_pkg::KIND_ENTER_CONFIG: begin
        ovr_valid_next = 1'b0;
        cur_mode_next  = slmb_pkg::MODE_CONFIG;
      end
      slmb_pkg::KIND_SET_COLOR: begin
        ovr_color_next = {item.red, item.green, item.blue};
        ovr_valid_next = 1'b1;
      end
      slmb_pkg::KIND_CLEAR_COLOR: begin
        ovr_valid_next = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mode    <= slmb_pkg::MODE_IDLE;
      ovr_valid   <= 1'b0;
      ovr_color   <= slmb_pkg::RGB_BLACK;
      cycle_mode  <= slmb_pkg::MODE_IDLE;
      cycle_base  <= slmb_pkg::palette_color(slmb_pkg::NODE_ID_RESET);
      cycle_phase <= 1'b0;
      phase_ticks <= 8'd0;
      shown       <= slmb_pkg::palette_color(slmb_pkg::NODE_ID_RESET);
      res_valid   <= 1'b0;
    end else begin
      if (take) begin
        cur_mode    <= cur_mode_next;
        ovr_valid   <= ovr_valid_next;
        ovr_color   <= ovr_color_next;
        cycle_mode  <= cycle_mode_next;
        cycle_base  <= cycle_base_next;
        cycle_phase <= cycle_phase_next;
        phase_ticks <= phase_ticks_next;
        shown       <= shown_next;
      end
      if (item_ready) begin
        res_valid <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.led_red     <= shown_next[23:16];
      res.led_green   <= shown_next[15:8];
      res.led_blue    <= shown_next[7:0];
      res.active_mode <= cur_mode_next;
      res.in_config   <= (cur_mode_next == slmb_pkg::MODE_CONFIG);
    end
  end

endmodule

[rtl/status_led_mode_blinker_top.sv]
// Status LED mode blinker: turns tick and control items into LED colour and mode.
// Input channel in_ch carries one item (kind, mode, red, green, blue); output
// channel out_ch carries one result for every item (LED colour, active_mode,
// in_config). Both use valid/ready; an item moves when both are high.
// The configuration port (cfg_we, cfg_index, cfg_data) writes node_id,
// blink_ticks and fast_blink_ticks at indexes 0, 1 and 2; write it only while
// no item is in flight.
// Path: a result passes through the input register, then through the state update
// into the result register, which offers it on out_ch.
// Throughput: one item per cycle while out_ch is not stalled; the state update for
// one item is a single short combinational step, so consecutive items follow
// each other directly. When the receiver stalls, the result register holds and
// the input register takes one more item before in_ch.ready drops.
// Reset (rst, synchronous) returns to idle mode with no override colour, the
// configuration registers to their defaults and the LED to white.
// Depends on slmb_pkg, slmb_if, slmb_cfg, slmb_in_reg and slmb_ctrl.
module status_led_mode_blinker_top (
  input  logic        clk,
  input  logic        rst,
  slmb_if.sink        in_ch,
  slmb_if.source      out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  slmb_pkg::cfg_t     cfg;
  logic               stage_valid;
  logic               stage_ready;
  slmb_pkg::in_item_t stage_data;

  slmb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  slmb_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_data     (in_ch.data),
    .stage_valid (stage_valid),
    .stage_ready (stage_ready),
    .stage_data  (stage_data)
  );

  slmb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (stage_valid),
    .item_ready (stage_ready),
    .item       (stage_data),
    .res_valid  (out_ch.valid),
    .res_ready  (out_ch.ready),
    .res        (out_ch.data)
  );

endmodule

[tb/sv/slmb_led_checker.sv]
// Checker for the status LED mode blinker: watches both channels and the register port.
// Keeps its own copy of mode, override and blink cycle state and compares every result.
// Depends on slmb_pkg for item, result and configuration types and the code constants.
module slmb_led_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  slmb_pkg::in_item_t in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  slmb_pkg::result_t  out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output int                 fail_count,
  output int                 pending
);

  slmb_pkg::cfg_t    regs;
  logic [1:0]        mode_req;
  logic              ovr_on;
  slmb_pkg::rgb_t    ovr_rgb;
  logic [1:0]        cyc_mode;
  slmb_pkg::rgb_t    cyc_base;
  logic              cyc_dark;
  logic [7:0]        cyc_count;
  slmb_pkg::rgb_t    led_rgb;
  slmb_pkg::result_t led_expected_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic slmb_pkg::rgb_t node_rgb(input logic [7:0] id);
    slmb_pkg::rgb_t c;
    c = slmb_pkg::RGB_WHITE;
    if (id < 8'd10) begin
      case (id[3:0])
        4'd1: c = {8'hFF, 8'h00, 8'h00};
        4'd2: c = {8'h00, 8'hFF, 8'h00};
        4'd3: c = {8'h00, 8'h00, 8'hFF};
        4'd4: c = {8'h00, 8'hFF, 8'hFF};
        4'd5: c = {8'hFF, 8'h00, 8'hFF};
        4'd6: c = {8'hFF, 8'hFF, 8'h00};
        4'd7: c = {8'd148, 8'd0, 8'd211};
        4'd8: c = {8'd255, 8'd90, 8'd0};
        4'd9: c = {8'd128, 8'd0, 8'd0};
        default: c = slmb_pkg::RGB_WHITE;
      endcase
    end
    return c;
  endfunction

  function automatic slmb_pkg::rgb_t base_rgb();
    return ovr_on ? ovr_rgb : node_rgb(regs.node_id);
  endfunction

  function automatic logic [7:0] phase_length();
    logic [7:0] n;
    n = (cyc_mode == slmb_pkg::MODE_CONFIG) ? regs.fast_blink_ticks : regs.blink_ticks;
    return (n == 8'd0) ? 8'd1 : n;
  endfunction

  task automatic restart_cycle();
    cyc_mode  = mode_req;
    cyc_base  = base_rgb();
    cyc_dark  = 1'b0;
    cyc_count = 8'd0;
    led_rgb   = (mode_req == slmb_pkg::MODE_CONFIG) ? slmb_pkg::RGB_WHITE : cyc_base;
  endtask

  task automatic advance_tick();
    cyc_count = cyc_count + 8'd1;
    if (cyc_count >= phase_length()) begin
      if (cyc_mode == slmb_pkg::MODE_LINKED || cyc_dark) begin
        restart_cycle();
      end else begin
        cyc_dark  = 1'b1;
        cyc_count = 8'd0;
        led_rgb   = slmb_pkg::RGB_BLACK;
      end
    end
    // A colour change only aborts the cycle outside config mode.
    if (mode_req != cyc_mode ||
        (cyc_mode != slmb_pkg::MODE_CONFIG && base_rgb() != cyc_base))
      restart_cycle();
  endtask

  task automatic apply_item(input slmb_pkg::in_item_t it, output slmb_pkg::result_t r);
    case (it.kind)
      slmb_pkg::KIND_TICK: advance_tick();
      slmb_pkg::KIND_SET_MODE: begin
        // An idle request is ignored while in config mode.
        if (!(mode_req == slmb_pkg::MODE_CONFIG && it.mode == slmb_pkg::MODE_IDLE))
          mode_req = it.mode;
      end
      slmb_pkg::KIND_ENTER_CONFIG: begin
        ovr_on   = 1'b0;
        mode_req = slmb_pkg::MODE_CONFIG;
      end
      slmb_pkg::KIND_SET_COLOR: begin
        ovr_rgb = {it.red, it.green, it.blue};
        ovr_on  = 1'b1;
      end
      slmb_pkg::KIND_CLEAR_COLOR: ovr_on = 1'b0;
      default: ;
    endcase
    r.led_red     = led_rgb[23:16];
    r.led_green   = led_rgb[15:8];
    r.led_blue    = led_rgb[7:0];
    r.active_mode = mode_req;
    r.in_config   = (mode_req == slmb_pkg::MODE_CONFIG);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    slmb_pkg::result_t want;
    if (rst) begin
      regs.node_id          = slmb_pkg::NODE_ID_RESET;
      regs.blink_ticks      = slmb_pkg::BLINK_TICKS_RESET;
      regs.fast_blink_ticks = slmb_pkg::FAST_BLINK_TICKS_RESET;
      mode_req = slmb_pkg::MODE_IDLE;
      ovr_on   = 1'b0;
      ovr_rgb  = slmb_pkg::RGB_BLACK;
      restart_cycle();
      led_expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          slmb_pkg::REG_NODE_ID:          regs.node_id = cfg_data;
          slmb_pkg::REG_BLINK_TICKS:      regs.blink_ticks = cfg_data;
          slmb_pkg::REG_FAST_BLINK_TICKS: regs.fast_blink_ticks = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (led_expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0h", $time, out_data);
          fail_count++;
        end else begin
          want = led_expected_q.pop_front();
          check_field("led_red", want.led_red, out_data.led_red);
          check_field("led_green", want.led_green, out_data.led_green);
          check_field("led_blue", want.led_blue, out_data.led_blue);
          check_field("active_mode", 8'(want.active_mode), 8'(out_data.active_mode));
          check_field("in_config", 8'(want.in_config), 8'(out_data.in_config));
        end
      end
      if (in_valid && in_ready) begin
        apply_item(in_data, want);
        led_expected_q.push_back(want);
      end
    end
    pending = led_expected_q.size();
  end

endmodule

[tb/sv/tb_top.sv]
// Top of the status LED mode blinker testbench: clock, reset, stimulus and verdict.
// Drives items in bursts, stalls the result side and rewrites the registers between phases.
// Depends on slmb_pkg, slmb_if, the block itself and slmb_led_checker.
module tb_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [2:0] KIND_UNUSED = slmb_pkg::KIND_CLEAR_COLOR + 3'd1;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  int         fail_count;
  int         pending;
  int         cycles;

  slmb_if #(.T(slmb_pkg::in_item_t)) in_ch ();
  slmb_if #(.T(slmb_pkg::result_t))  out_ch ();

  status_led_mode_blinker_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  slmb_led_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_data    (in_ch.data),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (out_ch.data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status_led_mode_blinker_top verification failed");
      $finish;
    end
  end

  // Result side: switches between always ready, coin-flip ready and occasional long stalls.
  initial begin
    int   style;
    int   style_left;
    int   hold;
    logic rdy;
    style      = 0;
    style_left = 0;
    hold       = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (style_left == 0) begin
        style      = $urandom_range(0, 2);
        style_left = $urandom_range(20, 80);
      end
      style_left--;
      case (style)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(0, 1));
        default: begin
          if (hold > 0) begin
            hold--;
            rdy = 1'b0;
          end else if ($urandom_range(0, 5) == 0) begin
            hold = $urandom_range(0, 7);
            rdy  = 1'b0;
          end else begin
            rdy = 1'b1;
          end
        end
      endcase
      out_ch.ready <= rdy;
    end
  end

  function automatic slmb_pkg::in_item_t make_item(input logic [2:0] kind,
                                                   input logic [1:0] mode,
                                                   input logic [7:0] r, input logic [7:0] g,
                                                   input logic [7:0] b);
    slmb_pkg::in_item_t it;
    it.kind  = kind;
    it.mode  = mode;
    it.red   = r;
    it.green = g;
    it.blue  = b;
    return it;
  endfunction

  function automatic logic [7:0] rand_level();
    logic [7:0] v;
    case ($urandom_range(0, 7))
      0: v = 8'h00;
      1: v = 8'hFF;
      default: v = 8'($urandom_range(0, 255));
    endcase
    return v;
  endfunction

  function automatic slmb_pkg::in_item_t rand_item(input int tick_pct);
    slmb_pkg::in_item_t it;
    int                 pick;
    it.mode  = 2'($urandom_range(0, 3));
    it.red   = rand_level();
    it.green = rand_level();
    it.blue  = rand_level();
    if ($urandom_range(0, 99) < tick_pct) begin
      it.kind = slmb_pkg::KIND_TICK;
    end else begin
      pick = $urandom_range(0, 19);
      if (pick < 6)       it.kind = slmb_pkg::KIND_SET_MODE;
      else if (pick < 9)  it.kind = slmb_pkg::KIND_ENTER_CONFIG;
      else if (pick < 14) it.kind = slmb_pkg::KIND_SET_COLOR;
      else if (pick < 18) it.kind = slmb_pkg::KIND_CLEAR_COLOR;
      else                it.kind = 3'(KIND_UNUSED + 3'($urandom_range(0, 2)));
    end
    return it;
  endfunction

  // Called and returns at a falling edge; valid stays high for a following item.
  task automatic send_item(input slmb_pkg::in_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic write_cfg(input logic [7:0] node, input logic [7:0] blink,
                           input logic [7:0] fast);
    cfg_we    <= 1'b1;
    cfg_index <= slmb_pkg::REG_NODE_ID;
    cfg_data  <= node;
    @(negedge clk);
    cfg_index <= slmb_pkg::REG_BLINK_TICKS;
    cfg_data  <= blink;
    @(negedge clk);
    cfg_index <= slmb_pkg::REG_FAST_BLINK_TICKS;
    cfg_data  <= fast;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int         n_items;
    int         tick_pct;
    int         burst_left;
    int         gap;
    logic [7:0] node;
    logic [7:0] blink;
    logic [7:0] fast;
    rst         = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    cfg_we      = 1'b0;
    cfg_index   = slmb_pkg::REG_NODE_ID;
    cfg_data    = 8'd0;
    burst_left  = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Reset state and an unknown kind under the default registers.
    send_item(make_item(slmb_pkg::KIND_TICK, slmb_pkg::MODE_IDLE, 8'h00, 8'h00, 8'h00));
    send_item(make_item(3'(KIND_UNUSED + 3'd2), slmb_pkg::MODE_CONFIG, 8'hFF, 8'hFF, 8'hFF));
    drain();
    write_cfg(8'd7, 8'd2, 8'd1);

    // A new cycle in the palette colour, its on phase, then its off phase.
    send_item(make_item(slmb_pkg::KIND_TICK, slmb_pkg::MODE_IDLE, 8'h00, 8'h00, 8'h00));
    send_item(make_item(slmb_pkg::KIND_TICK, slmb_pkg::MODE_IDLE, 8'h00, 8'h00, 8'h00));
    send_item(make_item(slmb_pkg::KIND_TICK, slmb_pkg::MODE_IDLE, 8'h00, 8'h00, 8'h00));
    send_item(make_item(slmb_pkg::KIND_TICK, slmb_pkg::MODE_IDLE, 8'h00, 8'h00, 8'h00));
    // A colour change aborts the cycle at the next tick.
    send_item(make_item(slmb_pkg::KIND_SET_COLOR, slmb_pkg::MODE_IDLE, 8'h00, 8'h00, 8'h00));
    send_item(make_item(slmb_pkg::KIND_TICK, slmb_pkg::MODE_IDLE, 8'h00, 8'h00, 8'h00));
    send_item(make_item(slmb_pkg::KIND_SET_COLOR, slmb_pkg::MODE_LINKED, 8'hFF, 8'hFF, 8'hFF));
    send_item(make_item(slmb_pkg::KIND_SET_MODE, slmb_pkg::MODE_IDLE, 8'h00, 8'h00, 8'h00));
    send_item(make_item(slmb_pkg::KIND_SET_MODE, slmb_pkg::MODE_HUB_WAIT, 8'h00, 8'h00, 8'h00));
    send_item(make_item(slmb_pkg::KIND_TICK, slmb_pkg::MODE_IDLE, 8'h00, 8'h00, 8'h00));
    // Linked mode holds the colour and restarts its single phase.
    send_item(make_item(slmb_pkg::KIND_SET_MODE, slmb_pkg::MODE_LINKED, 8'h00, 8'h00, 8'h00));
    send_item(make_item(slmb_pkg::KIND_TICK, slmb_pkg::MODE_IDLE, 8'h00, 8'h00, 8'h00));
    send_item(make_item(slmb_pkg::KIND_TICK, slmb_pkg::MODE_IDLE, 8'h00, 8'h00, 8'h00));
    send_item(make_item(slmb_pkg::KIND_TICK, slmb_pkg::MODE_IDLE, 8'h00, 8'h00, 8'h00));
    // Entering config clears the override and blinks white fast.
    send_item(make_item(slmb_pkg::KIND_ENTER_CONFIG, slmb_pkg::MODE_IDLE, 8'h00, 8'h00, 8'h00));
    send_item(make_item(slmb_pkg::KIND_TICK, slmb_pkg::MODE_IDLE, 8'h00, 8'h00, 8'h00));
    send_item(make_item(slmb_pkg::KIND_TICK, slmb_pkg::MODE_IDLE, 8'h00, 8'h00, 8'h00));
    send_item(make_item(slmb_pkg::KIND_TICK, slmb_pkg::MODE_IDLE, 8'h00, 8'h00, 8'h00));
    send_item(make_item(slmb_pkg::KIND_SET_MODE, slmb_pkg::MODE_IDLE, 8'h00, 8'h00, 8'h00));
    send_item(make_item(slmb_pkg::KIND_SET_COLOR, slmb_pkg::MODE_IDLE, 8'h12, 8'h34, 8'h56));
    send_item(make_item(slmb_pkg::KIND_TICK, slmb_pkg::MODE_IDLE, 8'h00, 8'h00, 8'h00));
    send_item(make_item(slmb_pkg::KIND_SET_MODE, slmb_pkg::MODE_CONFIG, 8'h00, 8'h00, 8'h00));
    send_item(make_item(slmb_pkg::KIND_SET_MODE, slmb_pkg::MODE_HUB_WAIT, 8'h00, 8'h00, 8'h00));
    send_item(make_item(slmb_pkg::KIND_TICK, slmb_pkg::MODE_IDLE, 8'h00, 8'h00, 8'h00));
    send_item(make_item(slmb_pkg::KIND_CLEAR_COLOR, slmb_pkg::MODE_IDLE, 8'h00, 8'h00, 8'h00));
    send_item(make_item(slmb_pkg::KIND_TICK, slmb_pkg::MODE_IDLE, 8'h00, 8'h00, 8'h00));
    send_item(make_item(KIND_UNUSED, slmb_pkg::MODE_LINKED, 8'hA5, 8'h5A, 8'hC3));
    send_item(make_item(3'(KIND_UNUSED + 3'd1), slmb_pkg::MODE_HUB_WAIT, 8'h3C, 8'hC3, 8'h5A));

    for (int p = 0; p < 8; p++) begin
      drain();
      case (p)
        0: begin node = 8'd3;   blink = 8'd1;   fast = 8'd255; end
        1: begin node = 8'd10;  blink = 8'd255; fast = 8'd1;   end
        2: begin node = 8'd0;   blink = 8'd3;   fast = 8'd0;   end
        3: begin node = 8'd9;   blink = 8'd0;   fast = 8'd2;   end
        4: begin node = 8'd255; blink = 8'd2;   fast = 8'd3;   end
        default: begin
          node  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 12));
          blink = 8'($urandom_range(0, 6));
          fast  = 8'($urandom_range(0, 6));
        end
      endcase
      write_cfg(node, blink, fast);
      n_items  = 90;
      tick_pct = 60;
      if (p == 1) begin
        // The longest phase length: one full blink cycle needs over five hundred ticks.
        n_items  = 560;
        tick_pct = 100;
        send_item(make_item(slmb_pkg::KIND_SET_MODE, slmb_pkg::MODE_HUB_WAIT,
                            8'h00, 8'h00, 8'h00));
      end
      for (int i = 0; i < n_items; i++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
          end
        end
        burst_left--;
        send_item(rand_item(tick_pct));
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (fail_count == 0)
      $display("status_led_mode_blinker_top verification clean");
    else
      $display("status_led_mode_blinker_top verification failed");
    $finish;
  end

endmodule

[status_led_mode_blinker_top.f]
rtl/slmb_pkg.sv
rtl/slmb_if.sv
rtl/slmb_cfg.sv
rtl/slmb_in_reg.sv
rtl/slmb_ctrl.sv
rtl/status_led_mode_blinker_top.sv
tb/sv/slmb_led_checker.sv
tb/sv/tb_top.sv
